// ===== hw/rtl/es2cal_pkg.sv =====
// Shared constants and calendar helper functions for the epoch seconds to
// calendar converter. No dependencies.
package es2cal_pkg;

   // Field widths of the transfer payloads
   localparam int EPOCH_W  = 32;
   localparam int SEC_W    = 6;
   localparam int MIN_W    = 6;
   localparam int HOUR_W   = 5;
   localparam int MDAY_W   = 5;
   localparam int MON_W    = 4;
   localparam int YEAR_W   = 8;
   localparam int WDAY_W   = 3;
   localparam int YDAY_W   = 9;

   // Working width of the shared adder/subtractor (33-bit biased seconds plus sign)
   localparam int ALU_W    = 34;
   // Quotient width of the day division and its step counter
   localparam int DAYQ_W   = 17;
   localparam int QUO_W    = 16;
   localparam int CNT_W    = 5;
   localparam int REM_W    = 17;

   localparam int SECS_PER_MIN  = 60;
   localparam int SECS_PER_HOUR = 3600;
   localparam int SECS_PER_DAY  = 86400;
   localparam int HOUR_QBITS    = 5;
   localparam int MIN_QBITS     = 6;

   // Whole days added to the input so the dividend is never negative
   localparam int DAY_BIAS      = 24856;
   localparam logic [ALU_W-1:0] EPOCH_BIAS =
      ALU_W'(64'(SECS_PER_DAY) * 64'(DAY_BIAS));
   // 1970-01-01 was a Thursday; fold the day bias into the weekday offset
   localparam int WDAY_BIAS     = ((4 - DAY_BIAS) % 7 + 7) % 7;

   localparam logic [YEAR_W-1:0] BASE_YEAR  = YEAR_W'(70);
   localparam logic [MON_W-1:0]  MONTH_LAST = MON_W'(11);

   // Gregorian leap rule over the years 1900..2155 reachable in eight bits
   function automatic logic is_leap(input logic [YEAR_W-1:0] yrs);
      return (yrs[1:0] == 2'b00) && (yrs != YEAR_W'(0)) && (yrs != YEAR_W'(200));
   endfunction

   function automatic logic [YDAY_W-1:0] year_len(input logic [YEAR_W-1:0] yrs);
      return is_leap(yrs) ? YDAY_W'(366) : YDAY_W'(365);
   endfunction

   function automatic logic [MDAY_W:0] month_len(input logic [MON_W-1:0] mon,
                                                 input logic leap);
      logic [MDAY_W:0] len;
      case (mon) inside
         4'd1:                   len = leap ? 6'd29 : 6'd28;
         4'd3, 4'd5, 4'd8, 4'd10: len = 6'd30;
         default:                len = 6'd31;
      endcase
      return len;
   endfunction

   // One quotient bit into a running residue modulo seven
   function automatic logic [WDAY_W-1:0] mod7_step(input logic [WDAY_W-1:0] r,
                                                   input logic bit_in);
      logic [WDAY_W:0] t;
      t = {r, bit_in};
      return (t >= 4'd7) ? WDAY_W'(t - 4'd7) : WDAY_W'(t);
   endfunction

   // Add a constant residue modulo seven
   function automatic logic [WDAY_W-1:0] mod7_add(input logic [WDAY_W-1:0] r,
                                                  input logic [WDAY_W-1:0] k);
      logic [WDAY_W:0] t;
      t = {1'b0, r} + {1'b0, k};
      return (t >= 4'd7) ? WDAY_W'(t - 4'd7) : WDAY_W'(t);
   endfunction

endpackage

// ===== hw/rtl/epoch_seconds_to_calendar.sv =====
// Epoch seconds to UTC calendar converter: one sequencer around a shared
// adder/subtractor. Depends on es2cal_pkg.

// One signed 32-bit seconds count goes in, one broken-down UTC date comes
// out. The converter works on one transfer at a time: req_ready is high only
// while it is idle. A conversion runs from acceptance to the result register
// as a sequence of steps around the single adder/subtractor: 17 restoring
// division steps by the day length, one to remove the day bias, one per whole
// year away from 1970 (up to 69) and one to leave the year phase, one per
// month stepped past (up to 11) and one to leave the month phase, eleven
// division steps for hour and minute, and one to load the result. The result
// sits in an output register until taken; a new request is accepted
// meanwhile, and a second finished result waits in the converter, holding
// req_ready low, until the first is taken.
module epoch_seconds_to_calendar (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [es2cal_pkg::EPOCH_W-1:0] req_epoch_seconds,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [es2cal_pkg::SEC_W-1:0]        rsp_second,
   output logic [es2cal_pkg::MIN_W-1:0]        rsp_minute,
   output logic [es2cal_pkg::HOUR_W-1:0]       rsp_hour,
   output logic [es2cal_pkg::MDAY_W-1:0]       rsp_day_of_month,
   output logic [es2cal_pkg::MON_W-1:0]        rsp_month,
   output logic [es2cal_pkg::YEAR_W-1:0]       rsp_years_since_1900,
   output logic [es2cal_pkg::WDAY_W-1:0]       rsp_weekday,
   output logic [es2cal_pkg::YDAY_W-1:0]       rsp_day_of_year
);
   import es2cal_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DAYDIV = 3'd1;
   localparam logic [2:0] S_DAYFIX = 3'd2;
   localparam logic [2:0] S_YEAR   = 3'd3;
   localparam logic [2:0] S_MONTH  = 3'd4;
   localparam logic [2:0] S_HOUR   = 3'd5;
   localparam logic [2:0] S_MIN    = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [ALU_W-1:0]  acc_ff, acc_in;
   logic [ALU_W-1:0]  dvs_ff, dvs_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [WDAY_W-1:0] wd_ff, wd_in;
   logic [YEAR_W-1:0] year_ff, year_in;
   logic [MON_W-1:0]  mon_ff, mon_in;
   logic [YDAY_W-1:0] doy_ff, doy_in;
   logic [MDAY_W-1:0] mday_ff, mday_in;
   logic [HOUR_W-1:0] hour_ff, hour_in;
   logic [MIN_W-1:0]  minute_ff, minute_in;
   logic [SEC_W-1:0]  second_ff, second_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [SEC_W-1:0]  out_second_ff, out_second_in;
   logic [MIN_W-1:0]  out_minute_ff, out_minute_in;
   logic [HOUR_W-1:0] out_hour_ff, out_hour_in;
   logic [MDAY_W-1:0] out_mday_ff, out_mday_in;
   logic [MON_W-1:0]  out_mon_ff, out_mon_in;
   logic [YEAR_W-1:0] out_year_ff, out_year_in;
   logic [WDAY_W-1:0] out_wd_ff, out_wd_in;
   logic [YDAY_W-1:0] out_doy_ff, out_doy_in;

   // Shared adder/subtractor operands and result
   logic [ALU_W-1:0]  alu_a, alu_b, alu_sum;
   logic              alu_sub;
   logic              acc_neg, alu_neg, qbit;
   logic [ALU_W-1:0]  div_rem;
   logic [QUO_W-1:0]  quo_next;
   logic [YEAR_W-1:0] year_prev;
   logic              out_free;

   assign acc_neg   = acc_ff[ALU_W-1];
   assign year_prev = year_ff - YEAR_W'(1);

   // Select operands for the shared unit
   always_comb begin
      alu_a   = acc_ff;
      alu_b   = '0;
      alu_sub = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            alu_a = {{(ALU_W-EPOCH_W){req_epoch_seconds[EPOCH_W-1]}}, req_epoch_seconds};
            alu_b = EPOCH_BIAS;
         end
         S_DAYDIV, S_HOUR, S_MIN: begin
            alu_b   = dvs_ff;
            alu_sub = 1'b1;
         end
         S_DAYFIX: begin
            alu_a   = ALU_W'(quo_ff);
            alu_b   = ALU_W'(DAY_BIAS);
            alu_sub = 1'b1;
         end
         S_YEAR: begin
            alu_b   = acc_neg ? ALU_W'(year_len(year_prev)) : ALU_W'(year_len(year_ff));
            alu_sub = !acc_neg;
         end
         S_MONTH: begin
            alu_b   = ALU_W'(month_len(mon_ff, is_leap(year_ff)));
            alu_sub = 1'b1;
         end
         default: begin
            alu_b = '0;
         end
      endcase
   end

   assign alu_sum  = alu_a + (alu_b ^ {ALU_W{alu_sub}}) + ALU_W'(alu_sub);
   assign alu_neg  = alu_sum[ALU_W-1];
   assign qbit     = !alu_neg;
   assign div_rem  = qbit ? alu_sum : acc_ff;
   assign quo_next = {quo_ff[QUO_W-2:0], qbit};
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Sequencer: advance one step of the current phase per cycle; the completion state holds until the output is free
   always_comb begin
      state_in  = state_ff;
      acc_in    = acc_ff;
      dvs_in    = dvs_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      wd_in     = wd_ff;
      year_in   = year_ff;
      mon_in    = mon_ff;
      doy_in    = doy_ff;
      mday_in   = mday_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               acc_in   = alu_sum;
               dvs_in   = ALU_W'(SECS_PER_DAY) << (DAYQ_W - 1);
               cnt_in   = CNT_W'(DAYQ_W - 1);
               quo_in   = '0;
               wd_in    = '0;
               state_in = S_DAYDIV;
            end
         end
         S_DAYDIV: begin
            acc_in = div_rem;
            quo_in = quo_next;
            wd_in  = mod7_step(wd_ff, qbit);
            dvs_in = dvs_ff >> 1;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) state_in = S_DAYFIX;
         end
         S_DAYFIX: begin
            // hold the seconds of the day, turn the quotient into signed days
            rem_in   = acc_ff[REM_W-1:0];
            acc_in   = alu_sum;
            wd_in    = mod7_add(wd_ff, WDAY_W'(WDAY_BIAS));
            year_in  = BASE_YEAR;
            state_in = S_YEAR;
         end
         S_YEAR: begin
            if (acc_neg) begin
               acc_in  = alu_sum;
               year_in = year_prev;
            end else if (!alu_neg) begin
               acc_in  = alu_sum;
               year_in = year_ff + YEAR_W'(1);
            end else begin
               doy_in   = acc_ff[YDAY_W-1:0];
               mon_in   = '0;
               state_in = S_MONTH;
            end
         end
         S_MONTH: begin
            if ((mon_ff != MONTH_LAST) && !alu_neg) begin
               acc_in = alu_sum;
               mon_in = mon_ff + MON_W'(1);
            end else begin
               mday_in  = acc_ff[MDAY_W-1:0] + MDAY_W'(1);
               acc_in   = ALU_W'(rem_ff);
               dvs_in   = ALU_W'(SECS_PER_HOUR) << (HOUR_QBITS - 1);
               cnt_in   = CNT_W'(HOUR_QBITS - 1);
               quo_in   = '0;
               state_in = S_HOUR;
            end
         end
         S_HOUR: begin
            acc_in = div_rem;
            quo_in = quo_next;
            dvs_in = dvs_ff >> 1;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               hour_in  = quo_next[HOUR_W-1:0];
               dvs_in   = ALU_W'(SECS_PER_MIN) << (MIN_QBITS - 1);
               cnt_in   = CNT_W'(MIN_QBITS - 1);
               quo_in   = '0;
               state_in = S_MIN;
            end
         end
         S_MIN: begin
            acc_in = div_rem;
            quo_in = quo_next;
            dvs_in = dvs_ff >> 1;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               minute_in = quo_next[MIN_W-1:0];
               second_in = div_rem[SEC_W-1:0];
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: load on completion, drop once the transfer is taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      out_second_in = out_second_ff;
      out_minute_in = out_minute_ff;
      out_hour_in   = out_hour_ff;
      out_mday_in   = out_mday_ff;
      out_mon_in    = out_mon_ff;
      out_year_in   = out_year_ff;
      out_wd_in     = out_wd_ff;
      out_doy_in    = out_doy_ff;
      if ((state_ff == S_DONE) && out_free) begin
         rsp_valid_in  = 1'b1;
         out_second_in = second_ff;
         out_minute_in = minute_ff;
         out_hour_in   = hour_ff;
         out_mday_in   = mday_ff;
         out_mon_in    = mon_ff;
         out_year_in   = year_ff;
         out_wd_in     = wd_ff;
         out_doy_in    = doy_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath and payload registers
   always_ff @(posedge clock) begin
      acc_ff        <= acc_in;
      dvs_ff        <= dvs_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      rem_ff        <= rem_in;
      wd_ff         <= wd_in;
      year_ff       <= year_in;
      mon_ff        <= mon_in;
      doy_ff        <= doy_in;
      mday_ff       <= mday_in;
      hour_ff       <= hour_in;
      minute_ff     <= minute_in;
      second_ff     <= second_in;
      out_second_ff <= out_second_in;
      out_minute_ff <= out_minute_in;
      out_hour_ff   <= out_hour_in;
      out_mday_ff   <= out_mday_in;
      out_mon_ff    <= out_mon_in;
      out_year_ff   <= out_year_in;
      out_wd_ff     <= out_wd_in;
      out_doy_ff    <= out_doy_in;
   end

   assign req_ready            = (state_ff == S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_second           = out_second_ff;
   assign rsp_minute           = out_minute_ff;
   assign rsp_hour             = out_hour_ff;
   assign rsp_day_of_month     = out_mday_ff;
   assign rsp_month            = out_mon_ff;
   assign rsp_years_since_1900 = out_year_ff;
   assign rsp_weekday          = out_wd_ff;
   assign rsp_day_of_year      = out_doy_ff;

   // Year stepping never leaves the range reachable from 32-bit seconds
   a_year_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_YEAR) |-> (year_ff >= YEAR_W'(1)) && (year_ff <= YEAR_W'(138)))
      else $error("year out of range during year stepping");

   // Month stepping works on a non-negative day of year below 366
   a_month_days: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MONTH) |-> !acc_neg && (acc_ff < ALU_W'(366)))
      else $error("day count out of range during month stepping");

   // The day division leaves a remainder below one day
   a_day_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DAYFIX) |-> (acc_ff < ALU_W'(SECS_PER_DAY)))
      else $error("day division remainder too large");

   // A result appears only on leaving the completion state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside completion");

   // Weekday residue stays a valid day of week
   a_wd_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_YEAR) |-> (wd_ff < WDAY_W'(7)))
      else $error("weekday residue out of range");

endmodule
